/* hw/rtl/alsd_pkg.sv */
// shared types, codes and helpers for the addressable led strip driver
`default_nettype none

package alsd_pkg;

	// command codes
	localparam logic [2:0] OP_TICK    = 3'd0;
	localparam logic [2:0] OP_SET     = 3'd1;
	localparam logic [2:0] OP_FILL    = 3'd2;
	localparam logic [2:0] OP_CLEAR   = 3'd3;
	localparam logic [2:0] OP_REFRESH = 3'd4;

	// sequencer phases
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_FILL  = 3'd1;
	localparam logic [2:0] PH_CLEAR = 3'd2;
	localparam logic [2:0] PH_HIGH  = 3'd3;
	localparam logic [2:0] PH_LOW   = 3'd4;
	localparam logic [2:0] PH_GAP   = 3'd5;

	// configuration register indexes
	localparam logic [2:0] REG_LED_COUNT  = 3'd0;
	localparam logic [2:0] REG_ZERO_HIGH  = 3'd1;
	localparam logic [2:0] REG_ZERO_LOW   = 3'd2;
	localparam logic [2:0] REG_ONE_HIGH   = 3'd3;
	localparam logic [2:0] REG_ONE_LOW    = 3'd4;
	localparam logic [2:0] REG_LATCH_GAP  = 3'd5;

	localparam int CFG_W  = 16;
	localparam int PIX_W  = 24;
	localparam int GRB_BITS = 24;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] pixel_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] brightness;
	} in_item_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic frame_done;
		logic rejected;
	} out_item_t;

	// c*br/255 truncated, division by 255 done as (x + (x>>8) + 1) >> 8
	function automatic logic [7:0] scale(input logic [7:0] c, input logic [7:0] br);
		logic [15:0] prod;
		logic [16:0] sum;
		prod = c * br;
		sum  = {1'b0, prod} + {9'b0, prod[15:8]} + 17'd1;
		return sum[15:8];
	endfunction

	// a timing count of zero behaves as one
	function automatic logic [15:0] at_least_one(input logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/alsd_pixel_ram.sv */
// pixel store: one write port, one registered read port with write forwarding
`default_nettype none

module alsd_pixel_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               waddr,
	input  wire logic [alsd_pkg::PIX_W-1:0]  wdata,
	input  wire logic                        re,
	input  wire logic [AW-1:0]               raddr,
	output logic      [alsd_pkg::PIX_W-1:0]  rdata
);

	logic [alsd_pkg::PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// same-address write and read in one cycle returns the new data
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata <= wdata;
			end else begin
				rdata <= mem[raddr];
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/addressable_led_strip_driver_top.sv */
// top level of the addressable led strip driver
// usage
//   in channel (in_valid, in_stall, in_item): one command item per accepted
//   cycle; an item is taken at a clock edge with in_valid high and in_stall low
//   every accepted item is one time step of the line: ticks, set pixel, fill,
//   clear and refresh all advance the frame sequencer by one step
//   out channel (out_valid, out_stall, out_item): exactly one result item for
//   each input item, in order, in the cycle after acceptance, from an output
//   register; line_level, busy_res, frame_done and rejected describe the
//   state at the start of that step
//   throughput is one item per cycle while in_stall is low; it is set by the
//   single-step sequencer and the registered read of the pixel store, which is
//   issued in the step entering a bit's high phase, consumed by the next step
//   when the receiver stalls, the output register holds and in_stall rises,
//   so at most one result is waiting at any time
//   cfg_we/cfg_index/cfg_data write the timing and led count registers
//   reset: registers go to their defaults and the pixel store is zeroed by a
//   clearing pass over all MAX_PIXELS entries, during which in_stall stays high
//   a frame lasts the sum of all bit times plus the latch gap, in items
`default_nettype none

module addressable_led_strip_driver_top #(
	parameter int MAX_PIXELS = 256
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire alsd_pkg::in_item_t          in_item,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output alsd_pkg::out_item_t              out_item,
	input  wire logic                        cfg_we,
	input  wire logic [2:0]                  cfg_index,
	input  wire logic [alsd_pkg::CFG_W-1:0]  cfg_data
);

	// store address width and pointer width (pointer can hold MAX_PIXELS)
	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int CW = $clog2(MAX_PIXELS + 1);

	// configuration registers
	logic [8:0]  led_count_q;
	logic [9:0]  zero_high_q;
	logic [9:0]  zero_low_q;
	logic [9:0]  one_high_q;
	logic [9:0]  one_low_q;
	logic [15:0] latch_gap_q;

	// sequencer state
	logic [2:0]    phase_q, phase_n;
	logic [CW-1:0] ptr_q, ptr_n;
	logic [4:0]    bit_q, bit_n;
	logic [15:0]   cnt_q, cnt_n;
	logic          pend_q, pend_n;      // high count not yet chosen by the bit
	logic [15:0]   cnt0_q, cnt0_n;      // high count for a zero bit
	logic [15:0]   cnt1_q, cnt1_n;      // high count for a one bit
	logic [23:0]   fill_q, fill_n;

	// clearing pass after reset
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	// output register
	logic                out_valid_q;
	alsd_pkg::out_item_t out_item_q;
	alsd_pkg::out_item_t res;

	// store ports
	logic                        st_we;
	logic [AW-1:0]               st_waddr;
	logic [alsd_pkg::PIX_W-1:0]  st_wdata;
	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [alsd_pkg::PIX_W-1:0]  ram_wdata;
	logic                        ram_re;
	logic [AW-1:0]               ram_raddr;
	logic [alsd_pkg::PIX_W-1:0]  ram_rdata;

	logic          acc;
	logic [CW-1:0] used;
	logic [23:0]   grb;
	logic [4:0]    bit_sel;
	logic          cur_bit;

	assign acc      = in_valid && !in_stall;
	assign in_stall = clr_q || (out_valid_q && out_stall);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// leds in use: min(led_count, MAX_PIXELS)
	assign used = (32'(led_count_q) < 32'(MAX_PIXELS)) ? CW'(led_count_q) : CW'(MAX_PIXELS);

	// current bit of the pixel word, sent as g, r, b msb first
	assign grb     = {ram_rdata[15:8], ram_rdata[23:16], ram_rdata[7:0]};
	assign bit_sel = 5'd23 - bit_q;
	assign cur_bit = grb[bit_sel];

	// one sequencer step per accepted item
	always_comb begin
		logic          go_high;
		logic          start;
		logic [CW-1:0] hi_ptr;
		logic [CW-1:0] ptr_inc;
		logic [15:0]   cur;
		logic [15:0]   dec;
		logic [4:0]    bit_inc;

		phase_n = phase_q;
		ptr_n   = ptr_q;
		bit_n   = bit_q;
		cnt_n   = cnt_q;
		pend_n  = pend_q;
		cnt0_n  = cnt0_q;
		cnt1_n  = cnt1_q;
		fill_n  = fill_q;
		st_we    = 1'b0;
		st_waddr = AW'(ptr_q);
		st_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = AW'(ptr_q);
		go_high = 1'b0;
		start   = 1'b0;
		hi_ptr  = '0;
		ptr_inc = ptr_q + 1'b1;
		cur     = cnt_q;
		dec     = '0;
		bit_inc = bit_q + 5'd1;

		res.line_level = (phase_q == alsd_pkg::PH_HIGH);
		res.busy_res   = (phase_q != alsd_pkg::PH_IDLE);
		res.frame_done = 1'b0;
		res.rejected   = (phase_q != alsd_pkg::PH_IDLE) &&
			((in_item.op == alsd_pkg::OP_SET) || (in_item.op == alsd_pkg::OP_FILL) ||
			 (in_item.op == alsd_pkg::OP_CLEAR) || (in_item.op == alsd_pkg::OP_REFRESH));

		case (phase_q)
			alsd_pkg::PH_IDLE: begin
				case (in_item.op)
					alsd_pkg::OP_SET: begin
						if (32'(in_item.pixel_index) < 32'(used)) begin
							st_we    = 1'b1;
							st_waddr = AW'(in_item.pixel_index);
							st_wdata = {in_item.red, in_item.green, in_item.blue};
						end else begin
							res.rejected = 1'b1;
						end
					end
					alsd_pkg::OP_FILL, alsd_pkg::OP_CLEAR: begin
						if (used != '0) begin
							if (in_item.op == alsd_pkg::OP_FILL) begin
								fill_n = {alsd_pkg::scale(in_item.red, in_item.brightness),
									alsd_pkg::scale(in_item.green, in_item.brightness),
									alsd_pkg::scale(in_item.blue, in_item.brightness)};
								phase_n = alsd_pkg::PH_FILL;
							end else begin
								fill_n  = '0;
								phase_n = alsd_pkg::PH_CLEAR;
							end
							ptr_n = '0;
						end
					end
					alsd_pkg::OP_REFRESH: begin
						start = 1'b1;
					end
					default: begin
					end
				endcase
			end
			alsd_pkg::PH_FILL, alsd_pkg::PH_CLEAR: begin
				if (ptr_q < used) begin
					st_we    = 1'b1;
					st_waddr = AW'(ptr_q);
					st_wdata = (phase_q == alsd_pkg::PH_FILL) ? fill_q : '0;
					ptr_n    = ptr_inc;
				end
				if (ptr_n >= used) begin
					start = 1'b1;
				end
			end
			alsd_pkg::PH_HIGH: begin
				// the pixel word read on entry is now available
				cur    = pend_q ? (cur_bit ? cnt1_q : cnt0_q) : cnt_q;
				dec    = (cur != 16'd0) ? cur - 16'd1 : cur;
				pend_n = 1'b0;
				if (dec == 16'd0) begin
					phase_n = alsd_pkg::PH_LOW;
					cnt_n   = alsd_pkg::at_least_one(cur_bit ? {6'd0, one_low_q} : {6'd0, zero_low_q});
				end else begin
					cnt_n = dec;
				end
			end
			alsd_pkg::PH_LOW: begin
				dec = (cnt_q != 16'd0) ? cnt_q - 16'd1 : cnt_q;
				cnt_n = dec;
				if (dec == 16'd0) begin
					if (bit_inc >= 5'(alsd_pkg::GRB_BITS)) begin
						bit_n = '0;
						ptr_n = ptr_inc;
					end else begin
						bit_n = bit_inc;
					end
					if (ptr_n >= used) begin
						phase_n = alsd_pkg::PH_GAP;
						cnt_n   = alsd_pkg::at_least_one(latch_gap_q);
					end else begin
						go_high = 1'b1;
						hi_ptr  = ptr_n;
					end
				end
			end
			alsd_pkg::PH_GAP: begin
				dec = (cnt_q != 16'd0) ? cnt_q - 16'd1 : cnt_q;
				cnt_n = dec;
				if (dec == 16'd0) begin
					phase_n = alsd_pkg::PH_IDLE;
					ptr_n   = '0;
					bit_n   = '0;
					res.frame_done = 1'b1;
				end
			end
			default: begin
				phase_n = alsd_pkg::PH_IDLE;
			end
		endcase

		// frame start from refresh or the end of a fill or clear
		if (start) begin
			ptr_n = '0;
			bit_n = '0;
			if (used == '0) begin
				phase_n = alsd_pkg::PH_IDLE;
				cnt_n   = '0;
			end else begin
				go_high = 1'b1;
				hi_ptr  = '0;
			end
		end

		// entering a high phase: fetch the pixel word, pick the count next step
		if (go_high) begin
			phase_n   = alsd_pkg::PH_HIGH;
			pend_n    = 1'b1;
			cnt_n     = '0;
			cnt0_n    = alsd_pkg::at_least_one({6'd0, zero_high_q});
			cnt1_n    = alsd_pkg::at_least_one({6'd0, one_high_q});
			ram_re    = 1'b1;
			ram_raddr = AW'(hi_ptr);
		end
	end

	// the clearing pass owns the write port until done
	assign ram_we    = clr_q || (acc && st_we);
	assign ram_waddr = clr_q ? clr_addr_q : st_waddr;
	assign ram_wdata = clr_q ? '0 : st_wdata;

	alsd_pixel_ram #(
		.DEPTH (MAX_PIXELS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (acc && ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// clearing pass, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == AW'(MAX_PIXELS - 1)) begin
				clr_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q <= 9'd0;
			zero_high_q <= 10'd56;
			zero_low_q  <= 10'd112;
			one_high_q  <= 10'd112;
			one_low_q   <= 10'd56;
			latch_gap_q <= 16'd9600;
		end else if (cfg_we) begin
			case (cfg_index)
				alsd_pkg::REG_LED_COUNT: led_count_q <= cfg_data[8:0];
				alsd_pkg::REG_ZERO_HIGH: zero_high_q <= cfg_data[9:0];
				alsd_pkg::REG_ZERO_LOW:  zero_low_q  <= cfg_data[9:0];
				alsd_pkg::REG_ONE_HIGH:  one_high_q  <= cfg_data[9:0];
				alsd_pkg::REG_ONE_LOW:   one_low_q   <= cfg_data[9:0];
				alsd_pkg::REG_LATCH_GAP: latch_gap_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer state advances only on accepted items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= alsd_pkg::PH_IDLE;
			ptr_q   <= '0;
			bit_q   <= '0;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
			cnt0_q  <= '0;
			cnt1_q  <= '0;
			fill_q  <= '0;
		end else if (acc) begin
			phase_q <= phase_n;
			ptr_q   <= ptr_n;
			bit_q   <= bit_n;
			cnt_q   <= cnt_n;
			pend_q  <= pend_n;
			cnt0_q  <= cnt0_n;
			cnt1_q  <= cnt1_n;
			fill_q  <= fill_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			out_item_q <= res;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/alsd_checker.sv */
// port-level assertions for the addressable led strip driver, bound to the top level
`default_nettype none

module alsd_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_stall,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire alsd_pkg::out_item_t         out_item
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// the line is only driven high inside a frame
	a_level_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.line_level |-> out_item.busy_res)
		else $error("line high while not busy");

	// a frame can only end while busy and with the line low
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.frame_done |-> out_item.busy_res && !out_item.line_level)
		else $error("frame done outside the latch gap");

	// an item is only taken when there is room for its result
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while result waits");

	// every accepted item shows its result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("no result after an accepted item");

endmodule

bind addressable_led_strip_driver_top alsd_checker u_alsd_checker (.*);

`default_nettype wire

/* tb/tb_top.sv */
// testbench for the addressable led strip driver: command stream, strip predictor, status check
`timescale 1ns / 100ps

module tb_top;

	localparam int NPIX = 256;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	alsd_pkg::in_item_t in_item;
	logic out_valid;
	logic out_stall = 1'b0;
	alsd_pkg::out_item_t out_item;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [alsd_pkg::CFG_W-1:0] cfg_data;

	// idle percentages for the sender and the receiver
	int send_idle_pct;
	int recv_idle_pct;
	int items_sent;
	int errors;

	// status items predicted for accepted commands, oldest first
	alsd_pkg::out_item_t pending_status[$];

	// predicted strip state
	logic [23:0] strip_rgb [NPIX];
	logic [8:0] walk_ptr;
	logic [4:0] bit_idx;
	logic [15:0] ticks_left;
	logic [2:0] seq_phase;
	logic [23:0] fill_rgb;

	// shadow of the timing and count registers
	logic [8:0] leds_cfg;
	logic [9:0] zero_hi;
	logic [9:0] zero_lo;
	logic [9:0] one_hi;
	logic [9:0] one_lo;
	logic [15:0] gap_len;

	addressable_led_strip_driver_top #(
		.MAX_PIXELS(NPIX)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial forever #4 clk = ~clk;

	// hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	// ---------------------------------------------------------------
	// strip predictor
	// ---------------------------------------------------------------

	function automatic logic [8:0] leds_in_use();
		return (leds_cfg > NPIX) ? 9'(NPIX) : leds_cfg;
	endfunction

	function automatic logic [15:0] min_one(input logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

	// colour times brightness over 255, truncated
	function automatic logic [7:0] shade8(input logic [7:0] c, input logic [7:0] br);
		int unsigned prod;
		prod = 32'(c) * 32'(br);
		return 8'(prod / 255);
	endfunction

	// bit of the current pixel on the wire, sent green, red, blue, msb first
	function automatic logic wire_bit();
		logic [23:0] rgb;
		logic [23:0] grb;
		rgb = (walk_ptr < NPIX) ? strip_rgb[walk_ptr[7:0]] : 24'd0;
		grb = {rgb[15:8], rgb[23:16], rgb[7:0]};
		return grb[23 - int'(bit_idx)];
	endfunction

	task automatic enter_high();
		seq_phase = alsd_pkg::PH_HIGH;
		ticks_left = min_one(wire_bit() ? 16'(one_hi) : 16'(zero_hi));
	endtask

	task automatic start_frame();
		walk_ptr = '0;
		bit_idx = '0;
		if (leds_in_use() == 9'd0) begin
			// nothing on the strip, so no frame at all
			seq_phase = alsd_pkg::PH_IDLE;
			ticks_left = '0;
		end else begin
			enter_high();
		end
	endtask

	task automatic reset_strip_model();
		for (int i = 0; i < NPIX; i++) begin
			strip_rgb[i] = '0;
		end
		walk_ptr = '0;
		bit_idx = '0;
		ticks_left = '0;
		seq_phase = alsd_pkg::PH_IDLE;
		fill_rgb = '0;
		leds_cfg = 9'd0;
		zero_hi = 10'd56;
		zero_lo = 10'd112;
		one_hi = 10'd112;
		one_lo = 10'd56;
		gap_len = 16'd9600;
	endtask

	// one step of the strip per accepted command: status reflects the state before the step
	task automatic advance_strip(input alsd_pkg::in_item_t cmd, output alsd_pkg::out_item_t res);
		logic [8:0] n;
		logic busy;
		n = leds_in_use();
		busy = (seq_phase != alsd_pkg::PH_IDLE);
		res.line_level = (seq_phase == alsd_pkg::PH_HIGH);
		res.busy_res = busy;
		res.frame_done = 1'b0;
		res.rejected = busy && cmd.op >= alsd_pkg::OP_SET && cmd.op <= alsd_pkg::OP_REFRESH;
		case (seq_phase)
		alsd_pkg::PH_IDLE: begin
			if (cmd.op == alsd_pkg::OP_SET) begin
				if (9'(cmd.pixel_index) < n) begin
					strip_rgb[cmd.pixel_index] = {cmd.red, cmd.green, cmd.blue};
				end else begin
					res.rejected = 1'b1;
				end
			end else if (cmd.op == alsd_pkg::OP_FILL || cmd.op == alsd_pkg::OP_CLEAR) begin
				if (n != 9'd0) begin
					fill_rgb = (cmd.op == alsd_pkg::OP_FILL) ?
						{shade8(cmd.red, cmd.brightness),
						shade8(cmd.green, cmd.brightness),
						shade8(cmd.blue, cmd.brightness)} : 24'd0;
					walk_ptr = '0;
					seq_phase = (cmd.op == alsd_pkg::OP_FILL) ?
						alsd_pkg::PH_FILL : alsd_pkg::PH_CLEAR;
				end
			end else if (cmd.op == alsd_pkg::OP_REFRESH) begin
				start_frame();
			end
		end
		alsd_pkg::PH_FILL, alsd_pkg::PH_CLEAR: begin
			if (walk_ptr < n) begin
				strip_rgb[walk_ptr[7:0]] = (seq_phase == alsd_pkg::PH_FILL) ? fill_rgb : 24'd0;
				walk_ptr++;
			end
			if (walk_ptr >= n) begin
				start_frame();
			end
		end
		alsd_pkg::PH_HIGH: begin
			if (ticks_left != 16'd0) begin
				ticks_left--;
			end
			if (ticks_left == 16'd0) begin
				seq_phase = alsd_pkg::PH_LOW;
				ticks_left = min_one(wire_bit() ? 16'(one_lo) : 16'(zero_lo));
			end
		end
		alsd_pkg::PH_LOW: begin
			if (ticks_left != 16'd0) begin
				ticks_left--;
			end
			if (ticks_left == 16'd0) begin
				bit_idx++;
				if (bit_idx >= 5'd24) begin
					bit_idx = '0;
					walk_ptr++;
				end
				if (walk_ptr >= n) begin
					seq_phase = alsd_pkg::PH_GAP;
					ticks_left = min_one(gap_len);
				end else begin
					enter_high();
				end
			end
		end
		alsd_pkg::PH_GAP: begin
			if (ticks_left != 16'd0) begin
				ticks_left--;
			end
			if (ticks_left == 16'd0) begin
				seq_phase = alsd_pkg::PH_IDLE;
				walk_ptr = '0;
				bit_idx = '0;
				res.frame_done = 1'b1;
			end
		end
		default: begin
			seq_phase = alsd_pkg::PH_IDLE;
		end
		endcase
	endtask

	// ---------------------------------------------------------------
	// status check
	// ---------------------------------------------------------------

	task automatic check_bit(input string fname, input logic want_v, input logic got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s expected %0b got %0b", $time, fname, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin : check_status
		alsd_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_status.size() == 0) begin
				$display("%0t: status item with none expected, expected nothing got %p",
					$time, out_item);
				errors++;
			end else begin
				want = pending_status.pop_front();
				check_bit("line_level", want.line_level, out_item.line_level);
				check_bit("busy_res", want.busy_res, out_item.busy_res);
				check_bit("frame_done", want.frame_done, out_item.frame_done);
				check_bit("rejected", want.rejected, out_item.rejected);
			end
		end
	end

	// receiver back-pressure, changes on the falling edge
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// ---------------------------------------------------------------
	// stimulus helpers, all entered and left at a falling edge
	// ---------------------------------------------------------------

	// offer one command item, predict its status once it is taken
	task automatic send_cmd(input alsd_pkg::in_item_t cmd);
		alsd_pkg::out_item_t res;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_item = cmd;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		advance_strip(cmd, res);
		pending_status.push_back(res);
		items_sent++;
		@(negedge clk);
	endtask

	// hold off the sender until every predicted status has come back
	task automatic wait_for_results();
		in_valid = 1'b0;
		while (pending_status.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
		alsd_pkg::REG_LED_COUNT: leds_cfg = val[8:0];
		alsd_pkg::REG_ZERO_HIGH: zero_hi = val[9:0];
		alsd_pkg::REG_ZERO_LOW: zero_lo = val[9:0];
		alsd_pkg::REG_ONE_HIGH: one_hi = val[9:0];
		alsd_pkg::REG_ONE_LOW: one_lo = val[9:0];
		alsd_pkg::REG_LATCH_GAP: gap_len = val;
		default: ;
		endcase
	endtask

	function automatic alsd_pkg::in_item_t make_cmd(input logic [2:0] op,
		input logic [7:0] idx, input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic [7:0] br);
		alsd_pkg::in_item_t c;
		c.op = op;
		c.pixel_index = idx;
		c.red = r;
		c.green = g;
		c.blue = b;
		c.brightness = br;
		return c;
	endfunction

	// random payload; set pixel indexes lean toward the used range
	function automatic alsd_pkg::in_item_t random_cmd(input logic [2:0] op);
		alsd_pkg::in_item_t c;
		c.op = op;
		if ($urandom_range(0, 9) < 6) begin
			c.pixel_index = 8'($urandom_range(0, leds_in_use()));
		end else begin
			c.pixel_index = 8'($urandom);
		end
		c.red = 8'($urandom);
		c.green = 8'($urandom);
		c.blue = 8'($urandom);
		case ($urandom_range(0, 9))
		0: c.brightness = 8'd0;
		1: c.brightness = 8'hff;
		default: c.brightness = 8'($urandom);
		endcase
		return c;
	endfunction

	function automatic logic [2:0] random_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return alsd_pkg::OP_TICK;
		if (r < 62) return alsd_pkg::OP_SET;
		if (r < 72) return alsd_pkg::OP_FILL;
		if (r < 80) return alsd_pkg::OP_CLEAR;
		if (r < 92) return alsd_pkg::OP_REFRESH;
		// codes above refresh behave as ticks
		return alsd_pkg::OP_REFRESH + 3'($urandom_range(1, 3));
	endfunction

	function automatic logic [2:0] strip_op();
		case ($urandom_range(0, 2))
		0: return alsd_pkg::OP_FILL;
		1: return alsd_pkg::OP_CLEAR;
		default: return alsd_pkg::OP_REFRESH;
		endcase
	endfunction

	// tick until the predicted strip is idle again
	task automatic drain_to_idle();
		while (seq_phase != alsd_pkg::PH_IDLE) begin
			send_cmd(random_cmd(alsd_pkg::OP_TICK));
		end
	endtask

	// short frames: a few leds and tick counts near the zero-acts-as-one edge
	task automatic shuffle_timing();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			write_reg(alsd_pkg::REG_LED_COUNT, 16'd0);
		end else if (r < 9) begin
			write_reg(alsd_pkg::REG_LED_COUNT, 16'($urandom_range(1, 2)));
		end else begin
			write_reg(alsd_pkg::REG_LED_COUNT, 16'($urandom_range(3, 5)));
		end
		if ($urandom_range(0, 1))
			write_reg(alsd_pkg::REG_ZERO_HIGH, 16'($urandom_range(0, 2)));
		if ($urandom_range(0, 1))
			write_reg(alsd_pkg::REG_ZERO_LOW, 16'($urandom_range(0, 2)));
		if ($urandom_range(0, 1))
			write_reg(alsd_pkg::REG_ONE_HIGH, 16'($urandom_range(0, 2)));
		if ($urandom_range(0, 1))
			write_reg(alsd_pkg::REG_ONE_LOW, 16'($urandom_range(0, 2)));
		if ($urandom_range(0, 1))
			write_reg(alsd_pkg::REG_LATCH_GAP, 16'($urandom_range(0, 24)));
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// led count is zero out of reset: strip commands are taken but do nothing
	task automatic test_empty_strip();
		send_cmd(make_cmd(alsd_pkg::OP_SET, 8'd0, 8'h12, 8'h34, 8'h56, 8'd0));
		send_cmd(make_cmd(alsd_pkg::OP_FILL, 8'd0, 8'hff, 8'hff, 8'hff, 8'hff));
		send_cmd(make_cmd(alsd_pkg::OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		send_cmd(make_cmd(alsd_pkg::OP_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		send_cmd(make_cmd(alsd_pkg::OP_REFRESH + 3'd1, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
		send_cmd(make_cmd(alsd_pkg::OP_REFRESH + 3'd3, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
	endtask

	// one led sent with short, distinct zero and one bit times and a short latch gap
	task automatic test_single_led_frame();
		wait_for_results();
		write_reg(alsd_pkg::REG_LED_COUNT, 16'd1);
		write_reg(alsd_pkg::REG_ZERO_HIGH, 16'd1);
		write_reg(alsd_pkg::REG_ZERO_LOW, 16'd2);
		write_reg(alsd_pkg::REG_ONE_HIGH, 16'd2);
		write_reg(alsd_pkg::REG_ONE_LOW, 16'd1);
		write_reg(alsd_pkg::REG_LATCH_GAP, 16'd6);
		send_cmd(make_cmd(alsd_pkg::OP_SET, 8'd0, 8'ha5, 8'hc3, 8'hf0, 8'd0));
		send_cmd(make_cmd(alsd_pkg::OP_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		drain_to_idle();
	endtask

	// set, range rejects, busy rejects, fill scaling and clear on one led
	task automatic test_commands_and_rejects();
		wait_for_results();
		write_reg(alsd_pkg::REG_LED_COUNT, 16'd1);
		write_reg(alsd_pkg::REG_ZERO_HIGH, 16'd0);
		write_reg(alsd_pkg::REG_ZERO_LOW, 16'd2);
		write_reg(alsd_pkg::REG_ONE_HIGH, 16'd3);
		write_reg(alsd_pkg::REG_ONE_LOW, 16'd1);
		write_reg(alsd_pkg::REG_LATCH_GAP, 16'd0);
		send_cmd(make_cmd(alsd_pkg::OP_SET, 8'd0, 8'hff, 8'hff, 8'hff, 8'd0));
		// index equal to the led count is out of range
		send_cmd(make_cmd(alsd_pkg::OP_SET, 8'd1, 8'h55, 8'haa, 8'h0f, 8'd0));
		send_cmd(make_cmd(alsd_pkg::OP_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		// every command is refused while the frame runs, unknown codes are not
		send_cmd(make_cmd(alsd_pkg::OP_SET, 8'd0, 8'h11, 8'h22, 8'h33, 8'd0));
		send_cmd(make_cmd(alsd_pkg::OP_FILL, 8'd0, 8'hff, 8'hff, 8'hff, 8'hff));
		send_cmd(make_cmd(alsd_pkg::OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		send_cmd(make_cmd(alsd_pkg::OP_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		send_cmd(make_cmd(alsd_pkg::OP_REFRESH + 3'd2, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		drain_to_idle();
		send_cmd(make_cmd(alsd_pkg::OP_FILL, 8'd0, 8'hff, 8'h01, 8'h80, 8'd128));
		drain_to_idle();
		send_cmd(make_cmd(alsd_pkg::OP_CLEAR, 8'd0, 8'hff, 8'hff, 8'hff, 8'hff));
		drain_to_idle();
	endtask

	// rounds of reprogrammed timing, then mostly well-formed command runs
	task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct);
		int stop_at;
		int burst;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			wait_for_results();
			shuffle_timing();
			burst = $urandom_range(30, 120);
			if ($urandom_range(0, 9) < 7) begin
				repeat ($urandom_range(1, 4)) send_cmd(random_cmd(alsd_pkg::OP_SET));
				send_cmd(random_cmd(strip_op()));
			end
			repeat (burst) send_cmd(random_cmd(random_op()));
			drain_to_idle();
		end
	endtask

	// store size limit and register writes wider than their fields, run without idling
	task automatic test_extremes();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		wait_for_results();
		// count above the store size is clipped to the store
		write_reg(alsd_pkg::REG_LED_COUNT, 16'd511);
		send_cmd(make_cmd(alsd_pkg::OP_SET, 8'hff, 8'h12, 8'h34, 8'h56, 8'd0));
		wait_for_results();
		write_reg(alsd_pkg::REG_LED_COUNT, 16'd256);
		send_cmd(make_cmd(alsd_pkg::OP_SET, 8'hfe, 8'h65, 8'h43, 8'h21, 8'd0));
		wait_for_results();
		// upper bits of each write but the latch gap fall outside the register
		write_reg(alsd_pkg::REG_LED_COUNT, 16'hfe01);
		write_reg(alsd_pkg::REG_ZERO_HIGH, 16'hfc00);
		write_reg(alsd_pkg::REG_ZERO_LOW, 16'h0401);
		write_reg(alsd_pkg::REG_ONE_HIGH, 16'hfc03);
		write_reg(alsd_pkg::REG_ONE_LOW, 16'h0802);
		write_reg(alsd_pkg::REG_LATCH_GAP, 16'd0);
		send_cmd(make_cmd(alsd_pkg::OP_SET, 8'd1, 8'hff, 8'hff, 8'hff, 8'd0));
		send_cmd(make_cmd(alsd_pkg::OP_SET, 8'd0, 8'h00, 8'h00, 8'h01, 8'd0));
		send_cmd(make_cmd(alsd_pkg::OP_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		drain_to_idle();
	endtask

	// ---------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = alsd_pkg::REG_LED_COUNT;
		cfg_data = '0;
		send_idle_pct = 35;
		recv_idle_pct = 49;
		items_sent = 0;
		errors = 0;
		reset_strip_model();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		// store clearing pass after reset
		while (in_stall) @(negedge clk);

		test_empty_strip();
		test_single_led_frame();
		test_commands_and_rejects();
		test_random_traffic(250, 35, 49);
		test_random_traffic(250, 49, 35);
		test_random_traffic(250, 0, 0);
		test_extremes();

		wait_for_results();
		repeat (8) @(negedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
